// ===== rtl/tra_pkg.sv =====
// shared types, constants and fixed-point helpers for the trackball rotation accumulator
`timescale 1ns / 1ps
`default_nettype none
package tra_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int MAX_DIM   = 4096;

    localparam int DIM_W   = 13;
    localparam int POS_W   = 12;
    localparam int Q_W     = 16;
    localparam int CV_W    = 27;
    localparam int MUL_W   = 27;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 56;
    localparam int RND_W   = 18;
    localparam int SUM_W   = 20;
    localparam int SQ_W    = 52;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int DIV_QW  = 16;
    localparam int NUM_W   = 40;
    localparam int REM_W   = 30;
    localparam int CNT_W   = 5;

    localparam logic [DIM_W-1:0] W_RESET = DIM_W'(640);
    localparam logic [DIM_W-1:0] H_RESET = DIM_W'(480);

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic {
        CMD_PRESS = 1'b0,
        CMD_MOVE  = 1'b1
    } cmd_t;

    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } unit_op_t;

    typedef struct packed {
        logic             cmd;
        logic [POS_W-1:0] x_pos;
        logic [POS_W-1:0] y_pos;
    } in_item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] rot_r0c0;
        logic signed [Q_W-1:0] rot_r0c1;
        logic signed [Q_W-1:0] rot_r0c2;
        logic signed [Q_W-1:0] rot_r1c0;
        logic signed [Q_W-1:0] rot_r1c1;
        logic signed [Q_W-1:0] rot_r1c2;
        logic signed [Q_W-1:0] rot_r2c0;
        logic signed [Q_W-1:0] rot_r2c1;
        logic signed [Q_W-1:0] rot_r2c2;
        logic                  updated;
    } out_item_t;

    typedef struct packed {
        logic              start;
        unit_op_t          op;
        logic [SQ_W-1:0]   arg;
        logic [NUM_W-1:0]  num;
        logic [ROOT_W-1:0] den;
    } unit_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ROOT_W-1:0] res;
    } unit_rsp_t;

    // magnitude round to nearest, ties away from zero, drop the fraction bits
    function automatic logic signed [RND_W-1:0] shr_round(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] m;
        logic [ACC_W-1:0] r;
        logic [RND_W-1:0] t;
        m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        r = (m + ACC_W'(ONE / 2)) >> FRAC_BITS;
        t = {1'b0, r[RND_W-2:0]};
        return v[ACC_W-1] ? -$signed(t) : $signed(t);
    endfunction

    function automatic logic signed [Q_W-1:0] sat_one(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(ONE)) begin
            return Q_W'(ONE);
        end else if (v < -SUM_W'(ONE)) begin
            return -Q_W'(ONE);
        end else begin
            return v[Q_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tra_divsqrt.sv =====
// shared radix-2 divider and radix-4 integer square root, one step per cycle
`timescale 1ns / 1ps
`default_nettype none
module tra_divsqrt import tra_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire unit_req_t req,
    output unit_rsp_t      rsp
);

    logic              busy_reg;
    logic              done_reg;
    unit_op_t          op_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] res_reg;
    logic [ROOT_W-1:0] res_next;
    logic [SQ_W-1:0]   opnd_reg;
    logic [ROOT_W-1:0] den_reg;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    always_comb begin
        if (op_reg == OP_SQRT) begin
            rem_sh = {rem_reg[REM_W-3:0], opnd_reg[SQ_W-1 -: 2]};
            trial  = REM_W'({res_reg, 2'b01});
        end else begin
            rem_sh = {rem_reg[REM_W-2:0], opnd_reg[SQ_W-1]};
            trial  = REM_W'(den_reg);
        end
        ge       = rem_sh >= trial;
        rem_next = ge ? rem_sh - trial : rem_sh;
        res_next = {res_reg[ROOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                den_reg  <= req.den;
                res_reg  <= '0;
                if (req.op == OP_SQRT) begin
                    cnt_reg  <= CNT_W'(ROOT_W - 1);
                    rem_reg  <= '0;
                    opnd_reg <= req.arg;
                end else begin
                    cnt_reg  <= CNT_W'(DIV_QW - 1);
                    rem_reg  <= REM_W'(req.num[NUM_W-1:DIV_QW]);
                    opnd_reg <= {req.num[DIV_QW-1:0], (SQ_W - DIV_QW)'(0)};
                end
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                res_reg  <= res_next;
                opnd_reg <= (op_reg == OP_SQRT) ? opnd_reg << 2 : opnd_reg << 1;
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule
`default_nettype wire

// ===== rtl/trackball_rotation_accumulator.sv =====
// top level: virtual trackball sequencer with shared multiplier and div/sqrt unit
`timescale 1ns / 1ps
`default_nettype none
// One item at a time. A press makes three divides and one square root, a move
// up to six divides and three square roots: each divide runs in the radix-2
// divider, each square root in the radix-4 root unit, and every product goes
// through the single 27x27 multiplier, one per cycle. s_ready is high only
// between items; the finished result waits in the output register while the
// block already takes the next request. The window registers are taken as 1
// when zero and clipped to 4096.
module trackball_rotation_accumulator import tra_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic             cfg_addr,
    input  wire logic [DIM_W-1:0] cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_item_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_item_t             m_data
);

    typedef enum logic [15:0] {
        ST_IDLE   = 16'h0001,
        ST_MAP    = 16'h0002,
        ST_MSQ    = 16'h0004,
        ST_MSQRT  = 16'h0008,
        ST_MDIV   = 16'h0010,
        ST_CMP    = 16'h0020,
        ST_CROSS  = 16'h0040,
        ST_CSQ    = 16'h0080,
        ST_CSQRT  = 16'h0100,
        ST_ADIV   = 16'h0200,
        ST_SINSQ  = 16'h0400,
        ST_SSQRT  = 16'h0800,
        ST_RMAT   = 16'h1000,
        ST_MMUL   = 16'h2000,
        ST_COMMIT = 16'h4000,
        ST_OUT    = 16'h8000
    } state_t;

    state_t                  st_reg;
    logic [DIM_W-1:0]        wreg_reg;
    logic [DIM_W-1:0]        hreg_reg;
    in_item_t                item_reg;
    logic                    upd_reg;
    logic                    go_reg;
    logic [1:0]              jb_reg;
    logic [2:0]              idx_reg;
    logic [1:0]              ri_reg;
    logic [1:0]              cj_reg;
    logic [3:0]              ent_reg;
    logic [1:0]              sub_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [ROOT_W-1:0]       len_reg;
    logic signed [Q_W-1:0]   sv_reg  [3];
    logic signed [Q_W-1:0]   pt_reg  [3];
    logic signed [CV_W-1:0]  cv_reg  [3];
    logic signed [Q_W-1:0]   ax_reg  [3];
    logic signed [Q_W-1:0]   r_reg   [9];
    logic signed [Q_W-1:0]   nm_reg  [9];
    logic signed [Q_W-1:0]   mat_reg [9];
    logic signed [Q_W-1:0]   cs_reg;
    logic signed [Q_W-1:0]   sn_reg;
    logic signed [Q_W-1:0]   aa_reg;
    logic signed [RND_W-1:0] e1_reg;
    logic                    m_valid_reg;
    out_item_t               out_reg;

    logic [DIM_W-1:0]        w_dim;
    logic [DIM_W-1:0]        h_dim;
    logic signed [14:0]      a_map;
    logic signed [14:0]      b_map;
    logic signed [MUL_W-1:0] mac_a;
    logic signed [MUL_W-1:0] mac_b;
    logic [1:0]              mac_n;
    logic                    mac_st;
    logic                    mac_done;
    logic signed [RND_W-1:0] rnd;
    logic signed [CV_W-1:0]  cv_sel;
    logic [CV_W-1:0]         cv_mag;
    logic signed [Q_W:0]     q_signed;
    logic signed [Q_W:0]     t_val;
    logic [1:0]              k_idx;
    logic                    off_neg;
    logic [3:0]              rk_idx;
    logic [3:0]              mk_idx;
    logic [3:0]              ent_last;
    unit_req_t               unit_req;
    unit_rsp_t               unit_rsp;

    tra_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (unit_req),
        .rsp     (unit_rsp)
    );

    function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end else begin
            return v;
        end
    endfunction

    assign w_dim  = dim_of(wreg_reg);
    assign h_dim  = dim_of(hreg_reg);
    assign a_map  = $signed({2'b00, item_reg.x_pos, 1'b0}) - $signed({2'b00, w_dim});
    assign b_map  = $signed({2'b00, h_dim}) - $signed({2'b00, item_reg.y_pos, 1'b0});
    assign rnd    = shr_round(acc_reg);
    assign t_val  = (Q_W + 1)'(ONE) - (Q_W + 1)'(cs_reg);
    assign k_idx  = 2'd3 - ri_reg - cj_reg;
    assign off_neg = (ri_reg == 2'd0 && cj_reg == 2'd1) || (ri_reg == 2'd1 && cj_reg == 2'd2)
                  || (ri_reg == 2'd2 && cj_reg == 2'd0);
    assign rk_idx = 4'({ri_reg, 1'b0}) + 4'(ri_reg) + 4'(idx_reg[1:0]);
    assign mk_idx = 4'({idx_reg[1:0], 1'b0}) + 4'(idx_reg[1:0]) + 4'(cj_reg);
    assign ent_last = 4'd8;

    // operand selection for the shared multiplier
    always_comb begin
        mac_a  = '0;
        mac_b  = '0;
        mac_n  = 2'd1;
        mac_st = 1'b1;
        case (st_reg)
            ST_MAP: begin
                case (jb_reg)
                    2'd0: begin
                        mac_a = MUL_W'(a_map);
                        mac_b = MUL_W'($signed({1'b0, h_dim}));
                    end
                    2'd1: begin
                        mac_a = MUL_W'(b_map);
                        mac_b = MUL_W'($signed({1'b0, w_dim}));
                    end
                    default: begin
                        mac_a = MUL_W'($signed({1'b0, w_dim}));
                        mac_b = MUL_W'($signed({1'b0, h_dim}));
                    end
                endcase
            end
            ST_MSQ, ST_CSQ: begin
                mac_n = 2'd3;
                mac_a = cv_reg[idx_reg[1:0] == 2'd3 ? 2'd0 : idx_reg[1:0]];
                mac_b = mac_a;
            end
            ST_CROSS: begin
                mac_n = (jb_reg == 2'd3) ? 2'd3 : 2'd2;
                case ({jb_reg, idx_reg[0]})
                    3'b000: begin
                        mac_a = MUL_W'(sv_reg[1]);
                        mac_b = MUL_W'(pt_reg[2]);
                    end
                    3'b001: begin
                        mac_a = -MUL_W'(pt_reg[1]);
                        mac_b = MUL_W'(sv_reg[2]);
                    end
                    3'b010: begin
                        mac_a = MUL_W'(pt_reg[0]);
                        mac_b = MUL_W'(sv_reg[2]);
                    end
                    3'b011: begin
                        mac_a = -MUL_W'(sv_reg[0]);
                        mac_b = MUL_W'(pt_reg[2]);
                    end
                    3'b100: begin
                        mac_a = MUL_W'(sv_reg[0]);
                        mac_b = MUL_W'(pt_reg[1]);
                    end
                    3'b101: begin
                        mac_a = -MUL_W'(pt_reg[0]);
                        mac_b = MUL_W'(sv_reg[1]);
                    end
                    default: begin
                        case (idx_reg[1:0])
                            2'd0: begin
                                mac_a = MUL_W'(sv_reg[0]);
                                mac_b = MUL_W'(pt_reg[0]);
                            end
                            2'd1: begin
                                mac_a = MUL_W'(sv_reg[1]);
                                mac_b = MUL_W'(pt_reg[1]);
                            end
                            default: begin
                                mac_a = MUL_W'(sv_reg[2]);
                                mac_b = MUL_W'(pt_reg[2]);
                            end
                        endcase
                    end
                endcase
            end
            ST_SINSQ: begin
                mac_a = MUL_W'(cs_reg);
                mac_b = MUL_W'(cs_reg);
            end
            ST_RMAT: begin
                case (sub_reg)
                    2'd0: begin
                        mac_a = MUL_W'(ax_reg[ri_reg == 2'd3 ? 2'd0 : ri_reg]);
                        mac_b = MUL_W'(ax_reg[cj_reg == 2'd3 ? 2'd0 : cj_reg]);
                    end
                    2'd1: begin
                        mac_a = MUL_W'(aa_reg);
                        mac_b = MUL_W'(t_val);
                    end
                    default: begin
                        mac_a = off_neg ? -MUL_W'(ax_reg[k_idx == 2'd3 ? 2'd0 : k_idx])
                                        : MUL_W'(ax_reg[k_idx == 2'd3 ? 2'd0 : k_idx]);
                        mac_b = MUL_W'(sn_reg);
                    end
                endcase
            end
            ST_MMUL: begin
                mac_n = 2'd3;
                mac_a = MUL_W'(r_reg[rk_idx > 4'd8 ? 4'd0 : rk_idx]);
                mac_b = MUL_W'(mat_reg[mk_idx > 4'd8 ? 4'd0 : mk_idx]);
            end
            default: begin
                mac_st = 1'b0;
            end
        endcase
    end

    assign mac_done = mac_st && (idx_reg == 3'(mac_n) + 3'd1);

    // divider operand and signed quotient for the normalizing divides
    assign cv_sel = cv_reg[jb_reg == 2'd3 ? 2'd0 : jb_reg];
    assign cv_mag = cv_sel[CV_W-1] ? CV_W'(-cv_sel) : CV_W'(cv_sel);
    assign q_signed = cv_sel[CV_W-1] ? -$signed({1'b0, unit_rsp.res[Q_W-1:0]})
                                     : $signed({1'b0, unit_rsp.res[Q_W-1:0]});

    always_comb begin
        unit_req.start = go_reg
                      || (mac_done && (st_reg == ST_MSQ || st_reg == ST_CSQ
                                       || st_reg == ST_SINSQ));
        unit_req.op    = go_reg ? OP_DIV : OP_SQRT;
        unit_req.arg   = (st_reg == ST_SINSQ)
                       ? SQ_W'(ACC_W'(ONE * ONE) - acc_reg) : acc_reg[SQ_W-1:0];
        unit_req.num   = (NUM_W'(cv_mag[24:0]) << FRAC_BITS) + NUM_W'(len_reg >> 1);
        unit_req.den   = len_reg;
    end

    // multiply-accumulate engine
    always_ff @(posedge aclk) begin
        if (st_reg == ST_IDLE || mac_done) begin
            idx_reg <= '0;
            acc_reg <= '0;
        end else if (mac_st) begin
            idx_reg <= idx_reg + 3'd1;
            if (idx_reg < 3'(mac_n)) begin
                prod_reg <= mac_a * mac_b;
            end
            if (idx_reg != '0) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wreg_reg <= W_RESET;
            hreg_reg <= H_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_WIDTH:  wreg_reg <= cfg_wdata;
                REG_HEIGHT: hreg_reg <= cfg_wdata;
                default:    wreg_reg <= wreg_reg;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            go_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int n = 0; n < 3; n++) begin
                sv_reg[n] <= '0;
            end
            for (int n = 0; n < 9; n++) begin
                mat_reg[n] <= (n % 4 == 0) ? Q_W'(ONE) : '0;
            end
        end else begin
            if (st_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg <= s_data;
                        jb_reg   <= '0;
                        upd_reg  <= 1'b0;
                        st_reg   <= ST_MAP;
                    end
                end
                ST_MAP: begin
                    if (mac_done) begin
                        cv_reg[jb_reg == 2'd3 ? 2'd0 : jb_reg] <= acc_reg[CV_W-1:0];
                        jb_reg <= jb_reg + 2'd1;
                        if (jb_reg == 2'd2) begin
                            st_reg <= ST_MSQ;
                        end
                    end
                end
                ST_MSQ: begin
                    if (mac_done) begin
                        st_reg <= ST_MSQRT;
                    end
                end
                ST_MSQRT: begin
                    if (unit_rsp.done) begin
                        len_reg <= unit_rsp.res;
                        jb_reg  <= '0;
                        go_reg  <= 1'b1;
                        st_reg  <= ST_MDIV;
                    end
                end
                ST_MDIV, ST_ADIV: begin
                    if (unit_rsp.done) begin
                        if (st_reg == ST_MDIV) begin
                            pt_reg[jb_reg == 2'd3 ? 2'd0 : jb_reg] <= q_signed[Q_W-1:0];
                        end else begin
                            ax_reg[jb_reg == 2'd3 ? 2'd0 : jb_reg] <= q_signed[Q_W-1:0];
                        end
                        if (jb_reg == 2'd2) begin
                            jb_reg <= '0;
                            st_reg <= (st_reg == ST_MDIV) ? ST_CMP : ST_SINSQ;
                        end else begin
                            jb_reg <= jb_reg + 2'd1;
                            go_reg <= 1'b1;
                        end
                    end else begin
                        go_reg <= 1'b0;
                    end
                end
                ST_CMP: begin
                    if (item_reg.cmd == CMD_PRESS) begin
                        sv_reg <= pt_reg;
                        st_reg <= ST_OUT;
                    end else if (pt_reg[0] == sv_reg[0] && pt_reg[1] == sv_reg[1]
                                 && pt_reg[2] == sv_reg[2]) begin
                        st_reg <= ST_OUT;
                    end else begin
                        st_reg <= ST_CROSS;
                    end
                end
                ST_CROSS: begin
                    if (mac_done) begin
                        jb_reg <= jb_reg + 2'd1;
                        if (jb_reg == 2'd3) begin
                            cs_reg <= sat_one(SUM_W'(rnd));
                            sv_reg <= pt_reg;
                            // parallel points, or no press yet: nothing to rotate
                            if (cv_reg[0] == '0 && cv_reg[1] == '0 && cv_reg[2] == '0) begin
                                st_reg <= ST_OUT;
                            end else begin
                                st_reg <= ST_CSQ;
                            end
                        end else begin
                            cv_reg[jb_reg] <= CV_W'(rnd);
                        end
                    end
                end
                ST_CSQ: begin
                    if (mac_done) begin
                        st_reg <= ST_CSQRT;
                    end
                end
                ST_CSQRT: begin
                    if (unit_rsp.done) begin
                        len_reg <= (unit_rsp.res == '0) ? ROOT_W'(1) : unit_rsp.res;
                        jb_reg  <= '0;
                        go_reg  <= 1'b1;
                        st_reg  <= ST_ADIV;
                    end
                end
                ST_SINSQ: begin
                    if (mac_done) begin
                        st_reg <= ST_SSQRT;
                    end
                end
                ST_SSQRT: begin
                    if (unit_rsp.done) begin
                        sn_reg  <= unit_rsp.res[Q_W-1:0];
                        ri_reg  <= '0;
                        cj_reg  <= '0;
                        ent_reg <= '0;
                        sub_reg <= '0;
                        st_reg  <= ST_RMAT;
                    end
                end
                ST_RMAT: begin
                    if (mac_done) begin
                        case (sub_reg)
                            2'd0: begin
                                aa_reg  <= rnd[Q_W-1:0];
                                sub_reg <= 2'd1;
                            end
                            2'd1: begin
                                e1_reg <= rnd;
                                if (ri_reg == cj_reg) begin
                                    r_reg[ent_reg > 4'd8 ? 4'd0 : ent_reg]
                                        <= sat_one(SUM_W'(rnd) + SUM_W'(cs_reg));
                                    sub_reg <= 2'd0;
                                end else begin
                                    sub_reg <= 2'd2;
                                end
                            end
                            default: begin
                                r_reg[ent_reg > 4'd8 ? 4'd0 : ent_reg]
                                    <= sat_one(SUM_W'(e1_reg) + SUM_W'(rnd));
                                sub_reg <= 2'd0;
                            end
                        endcase
                        if (sub_reg == 2'd2 || (sub_reg == 2'd1 && ri_reg == cj_reg)) begin
                            if (ent_reg == ent_last) begin
                                ri_reg  <= '0;
                                cj_reg  <= '0;
                                ent_reg <= '0;
                                st_reg  <= ST_MMUL;
                            end else begin
                                ent_reg <= ent_reg + 4'd1;
                                cj_reg  <= (cj_reg == 2'd2) ? 2'd0 : cj_reg + 2'd1;
                                if (cj_reg == 2'd2) begin
                                    ri_reg <= ri_reg + 2'd1;
                                end
                            end
                        end
                    end
                end
                ST_MMUL: begin
                    if (mac_done) begin
                        nm_reg[ent_reg > 4'd8 ? 4'd0 : ent_reg] <= sat_one(SUM_W'(rnd));
                        ent_reg <= ent_reg + 4'd1;
                        cj_reg  <= (cj_reg == 2'd2) ? 2'd0 : cj_reg + 2'd1;
                        if (cj_reg == 2'd2) begin
                            ri_reg <= ri_reg + 2'd1;
                        end
                        if (ent_reg == ent_last) begin
                            st_reg <= ST_COMMIT;
                        end
                    end
                end
                ST_COMMIT: begin
                    mat_reg <= nm_reg;
                    upd_reg <= 1'b1;
                    st_reg  <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg.rot_r0c0 <= mat_reg[0];
                        out_reg.rot_r0c1 <= mat_reg[1];
                        out_reg.rot_r0c2 <= mat_reg[2];
                        out_reg.rot_r1c0 <= mat_reg[3];
                        out_reg.rot_r1c1 <= mat_reg[4];
                        out_reg.rot_r1c2 <= mat_reg[5];
                        out_reg.rot_r2c0 <= mat_reg[6];
                        out_reg.rot_r2c1 <= mat_reg[7];
                        out_reg.rot_r2c2 <= mat_reg[8];
                        out_reg.updated  <= upd_reg;
                        st_reg           <= ST_IDLE;
                    end
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (st_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while a previous one is in flight");

    a_unit_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_req.start |-> !unit_rsp.busy)
        else $error("div/sqrt unit restarted while busy");

    a_diag_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.rot_r0c0 <= Q_W'(ONE) && m_data.rot_r0c0 >= -Q_W'(ONE)
                  && m_data.rot_r1c1 <= Q_W'(ONE) && m_data.rot_r1c1 >= -Q_W'(ONE)
                  && m_data.rot_r2c2 <= Q_W'(ONE) && m_data.rot_r2c2 >= -Q_W'(ONE)))
        else $error("matrix entry outside unit range");

endmodule
`default_nettype wire
